// ===== hw/rtl/tfcc_pkg.sv =====
// Shared types, constants and helpers for the timed Cartesian control core.
// Used by the controller, the datapath, the top level and the checker.
package tfcc_pkg;

  localparam int MAX_SAMPLES  = 64;
  localparam int NUM_JOINTS   = 7;
  localparam int FRAC_BITS    = 16;

  localparam int WRENCH_DIM   = 6;
  localparam int ERR_DIM      = 12;
  localparam int TAIL_SAMPLES = 2;
  localparam int SAMPLE_WORDS = 128;

  localparam int OFS_FF   = 1;
  localparam int OFS_POS  = 7;
  localparam int OFS_GAIN = 13;

  localparam int SIDX_W  = $clog2(MAX_SAMPLES);
  localparam int OFS_W   = $clog2(SAMPLE_WORDS);
  localparam int ADDR_W  = SIDX_W + OFS_W;
  localparam int STORE_WORDS = MAX_SAMPLES * SAMPLE_WORDS;
  localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W   = $clog2(WRENCH_DIM);
  localparam int ACC_W   = 52;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_COUNT = 2'd1,
    REQ_MEAS  = 2'd2,
    REQ_COL   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_CHK,
    ST_S_RD,
    ST_S_CMP,
    ST_E_RD,
    ST_E_CALC,
    ST_F_RD,
    ST_F_LD,
    ST_G_RD,
    ST_G_MUL,
    ST_G_ACC,
    ST_W_WR,
    ST_C_MUL,
    ST_C_ACC,
    ST_C_OUT
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              rd_en;
    logic              rd_search;
    logic [SIDX_W-1:0] search_idx;
    logic [OFS_W-1:0]  rd_ofs;
    logic              set_sel;
    logic [SIDX_W-1:0] sel_value;
    logic              clear_drive;
    logic              err_wr;
    logic              acc_clr;
    logic              acc_ld_ff;
    logic              mul_gain;
    logic              mul_col;
    logic              acc_add;
    logic              drive_wr;
    logic [IDX_W-1:0]  idx;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic              count_zero;
    logic              time_later;
    logic [SIDX_W-1:0] base;
    logic              out_free;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sd2147483647);
    lo = -ACC_W'(64'sd2147483648);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/tfcc_ctrl.sv =====
// Sequencing state machine of the control core: sample search, error,
// drive vector and torque loops. Depends on tfcc_pkg.
module tfcc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        req_type,
  output logic              in_stall,
  input  tfcc_pkg::dp_stat_t stat,
  output tfcc_pkg::dp_cmd_t  cmd
);
  import tfcc_pkg::*;

  state_t            state, state_next;
  logic [SIDX_W-1:0] i_cnt, i_cnt_next;
  logic [IDX_W-1:0]  r_cnt, r_cnt_next;
  logic [IDX_W-1:0]  k_cnt, k_cnt_next;
  logic              accept;
  req_t              req;
  logic [OFS_W-1:0]  gain_col;

  assign req      = req_t'(req_type);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  // Only error columns 0-2 and 6-8 are non-zero.
  assign gain_col = (k_cnt < IDX_W'(3)) ? OFS_W'(k_cnt) : OFS_W'(k_cnt) + OFS_W'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_cnt <= '0;
      r_cnt <= '0;
      k_cnt <= '0;
    end else begin
      state <= state_next;
      i_cnt <= i_cnt_next;
      r_cnt <= r_cnt_next;
      k_cnt <= k_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    i_cnt_next = i_cnt;
    r_cnt_next = r_cnt;
    k_cnt_next = k_cnt;
    case (state)
      ST_IDLE: begin
        if (accept && req == REQ_MEAS && !stat.count_zero) begin
          state_next = ST_S_CHK;
          i_cnt_next = '0;
        end else if (accept && req == REQ_COL) begin
          state_next = ST_C_MUL;
          k_cnt_next = '0;
        end
      end
      ST_S_CHK: begin
        if (i_cnt == stat.base) begin
          state_next = ST_E_RD;
          r_cnt_next = '0;
        end else begin
          state_next = ST_S_RD;
        end
      end
      ST_S_RD: state_next = ST_S_CMP;
      ST_S_CMP: begin
        if (stat.time_later) begin
          state_next = ST_E_RD;
          r_cnt_next = '0;
        end else begin
          state_next = ST_S_CHK;
          i_cnt_next = i_cnt + SIDX_W'(1);
        end
      end
      ST_E_RD: state_next = ST_E_CALC;
      ST_E_CALC: begin
        if (r_cnt == IDX_W'(WRENCH_DIM - 1)) begin
          state_next = ST_F_RD;
          r_cnt_next = '0;
        end else begin
          state_next = ST_E_RD;
          r_cnt_next = r_cnt + IDX_W'(1);
        end
      end
      ST_F_RD: state_next = ST_F_LD;
      ST_F_LD: begin
        state_next = ST_G_RD;
        k_cnt_next = '0;
      end
      ST_G_RD:  state_next = ST_G_MUL;
      ST_G_MUL: state_next = ST_G_ACC;
      ST_G_ACC: begin
        if (k_cnt == IDX_W'(WRENCH_DIM - 1)) begin
          state_next = ST_W_WR;
        end else begin
          state_next = ST_G_RD;
          k_cnt_next = k_cnt + IDX_W'(1);
        end
      end
      ST_W_WR: begin
        if (r_cnt == IDX_W'(WRENCH_DIM - 1)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_F_RD;
          r_cnt_next = r_cnt + IDX_W'(1);
        end
      end
      ST_C_MUL: state_next = ST_C_ACC;
      ST_C_ACC: begin
        if (k_cnt == IDX_W'(WRENCH_DIM - 1)) begin
          state_next = ST_C_OUT;
        end else begin
          state_next = ST_C_MUL;
          k_cnt_next = k_cnt + IDX_W'(1);
        end
      end
      ST_C_OUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.search_idx = i_cnt;
    cmd.idx        = k_cnt;
    case (state)
      ST_IDLE: begin
        cmd.clear_drive = accept && req == REQ_MEAS && stat.count_zero;
        cmd.acc_clr     = accept && req == REQ_COL;
      end
      ST_S_CHK: begin
        cmd.set_sel   = (i_cnt == stat.base);
        cmd.sel_value = stat.base;
      end
      ST_S_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_search = 1'b1;
        cmd.rd_ofs    = '0;
      end
      ST_S_CMP: begin
        cmd.set_sel   = stat.time_later;
        cmd.sel_value = (i_cnt == '0) ? '0 : i_cnt - SIDX_W'(1);
      end
      ST_E_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_ofs = OFS_W'(OFS_POS) + OFS_W'(r_cnt);
      end
      ST_E_CALC: begin
        cmd.err_wr = 1'b1;
        cmd.idx    = r_cnt;
      end
      ST_F_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_ofs = OFS_W'(OFS_FF) + OFS_W'(r_cnt);
      end
      ST_F_LD: cmd.acc_ld_ff = 1'b1;
      ST_G_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_ofs = OFS_W'(OFS_GAIN) + OFS_W'(r_cnt) * OFS_W'(ERR_DIM) + gain_col;
      end
      ST_G_MUL: cmd.mul_gain = 1'b1;
      ST_G_ACC: cmd.acc_add  = 1'b1;
      ST_W_WR: begin
        cmd.drive_wr = 1'b1;
        cmd.idx      = r_cnt;
      end
      ST_C_MUL: cmd.mul_col  = 1'b1;
      ST_C_ACC: cmd.acc_add  = 1'b1;
      ST_C_OUT: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/tfcc_dp.sv =====
// Datapath of the control core: plan store, item registers, error and drive
// registers, shared multiply-accumulate and the result register. Uses tfcc_pkg.
module tfcc_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          req_type,
  input  logic [12:0]         load_addr,
  input  logic signed [63:0]  load_value,
  input  logic [62:0]         meas_time,
  input  logic signed [31:0]  vec_0,
  input  logic signed [31:0]  vec_1,
  input  logic signed [31:0]  vec_2,
  input  logic signed [31:0]  vec_3,
  input  logic signed [31:0]  vec_4,
  input  logic signed [31:0]  vec_5,
  input  logic [2:0]          col_index,
  input  tfcc_pkg::dp_cmd_t   cmd,
  output tfcc_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  joint_torque,
  output logic [2:0]          joint_index,
  output logic [5:0]          chosen_sample,
  output logic                plan_empty,
  output logic                last
);
  import tfcc_pkg::*;

  logic [63:0]              plan_mem [STORE_WORDS];
  logic [63:0]              rdata;
  logic [ADDR_W-1:0]        rd_addr;
  logic [COUNT_W-1:0]       count;
  logic [SIDX_W-1:0]        sel;
  logic [62:0]              now_q;
  logic [2:0]               col_q;
  logic signed [31:0]       vec_q   [WRENCH_DIM];
  logic signed [31:0]       err_q   [WRENCH_DIM];
  logic signed [31:0]       drive_q [WRENCH_DIM];
  logic signed [63:0]       prod;
  logic signed [63:0]       prod_sh;
  logic signed [ACC_W-1:0]  acc;
  logic signed [31:0]       word_lo;
  logic signed [ACC_W-1:0]  diff;
  logic                     load_wr;
  req_t                     req;

  assign req     = req_t'(req_type);
  assign load_wr = cmd.accept && req == REQ_LOAD;
  assign word_lo = rdata[31:0];
  assign rd_addr = {cmd.rd_search ? cmd.search_idx : sel, cmd.rd_ofs};
  assign diff    = ACC_W'(word_lo) - ACC_W'(vec_q[cmd.idx]);
  assign prod_sh = prod >>> FRAC_BITS;

  assign stat.count_zero = (count == '0);
  assign stat.time_later = $signed(rdata) > $signed({1'b0, now_q});
  assign stat.base       = (count > COUNT_W'(TAIL_SAMPLES)) ?
                           SIDX_W'(count - COUNT_W'(TAIL_SAMPLES)) : '0;
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (load_wr) begin
      plan_mem[load_addr[ADDR_W-1:0]] <= load_value;
    end
    if (cmd.rd_en) begin
      rdata <= plan_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_q    <= meas_time;
      col_q    <= col_index;
      vec_q[0] <= vec_0;
      vec_q[1] <= vec_1;
      vec_q[2] <= vec_2;
      vec_q[3] <= vec_3;
      vec_q[4] <= vec_4;
      vec_q[5] <= vec_5;
    end
    if (cmd.err_wr) begin
      err_q[cmd.idx] <= sat32(diff);
    end
    if (cmd.mul_gain) begin
      prod <= word_lo * err_q[cmd.idx];
    end else if (cmd.mul_col) begin
      prod <= vec_q[cmd.idx] * drive_q[cmd.idx];
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_ld_ff) begin
      acc <= ACC_W'(word_lo);
    end else if (cmd.acc_add) begin
      acc <= acc + prod_sh[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sel   <= '0;
      for (int j = 0; j < WRENCH_DIM; j++) begin
        drive_q[j] <= '0;
      end
    end else begin
      if (cmd.accept && req == REQ_COUNT) begin
        if (load_value < 0) begin
          count <= '0;
        end else if (load_value > 64'(MAX_SAMPLES)) begin
          count <= COUNT_W'(MAX_SAMPLES);
        end else begin
          count <= load_value[COUNT_W-1:0];
        end
      end
      if (cmd.clear_drive) begin
        sel <= '0;
        for (int j = 0; j < WRENCH_DIM; j++) begin
          drive_q[j] <= '0;
        end
      end
      if (cmd.set_sel) begin
        sel <= cmd.sel_value;
      end
      if (cmd.drive_wr) begin
        drive_q[cmd.idx] <= sat32(acc);
      end
    end
  end

  // The result register frees its slot when the beat is taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      joint_torque  <= stat.count_zero ? '0 : sat32(acc);
      joint_index   <= col_q;
      chosen_sample <= 6'(sel);
      plan_empty    <= stat.count_zero;
      last          <= (col_q == 3'(NUM_JOINTS - 1));
    end
  end

endmodule

// ===== hw/rtl/timed_ff_fb_cartesian_control_core.sv =====
// Top level of the timed feed-forward / feedback Cartesian control core.
// Joins the sequencing state machine and the datapath; uses tfcc_pkg.
//
// One input channel (in_valid / in_stall) carries four kinds of beat chosen
// by req_type: a plan word write, a sample count write, a measurement and a
// Jacobian column. One output channel (out_valid / out_stall) carries one
// torque beat for each column beat and nothing for the other kinds.
// Plan word and count beats are taken without stalling the input.
// A measurement walks the sample times (up to 62 samples) by check, read and
// compare, then forms the errors from the position words and builds each
// drive row from a feed-forward read and gain read, multiply and accumulate
// steps, using the single plan store read port and the shared multiplier.
// A measurement on an empty plan only clears the drive vector and sample.
// A column beat runs six multiply and accumulate steps, then the load of the
// result register. The result is held there until taken, and the next beat
// is accepted meanwhile; only a further column beat waits for it to free.
// Reset clears the sample count, the drive vector, the selected sample and
// the output valid; plan store contents are undefined until written.
module timed_ff_fb_cartesian_control_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [12:0]        load_addr,
  input  logic signed [63:0] load_value,
  input  logic [62:0]        meas_time,
  input  logic signed [31:0] vec_0,
  input  logic signed [31:0] vec_1,
  input  logic signed [31:0] vec_2,
  input  logic signed [31:0] vec_3,
  input  logic signed [31:0] vec_4,
  input  logic signed [31:0] vec_5,
  input  logic [2:0]         col_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] joint_torque,
  output logic [2:0]         joint_index,
  output logic [5:0]         chosen_sample,
  output logic               plan_empty,
  output logic               last
);
  import tfcc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tfcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tfcc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req_type),
    .load_addr     (load_addr),
    .load_value    (load_value),
    .meas_time     (meas_time),
    .vec_0         (vec_0),
    .vec_1         (vec_1),
    .vec_2         (vec_2),
    .vec_3         (vec_3),
    .vec_4         (vec_4),
    .vec_5         (vec_5),
    .col_index     (col_index),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .joint_torque  (joint_torque),
    .joint_index   (joint_index),
    .chosen_sample (chosen_sample),
    .plan_empty    (plan_empty),
    .last          (last)
  );

endmodule

// ===== hw/rtl/tfcc_checker.sv =====
// Port-level checks for the timed Cartesian control core, bound to the top
// level. Depends on tfcc_pkg.
module tfcc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] joint_torque,
  input logic [2:0]         joint_index,
  input logic               plan_empty,
  input logic               last
);
  import tfcc_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(joint_torque))
    else $error("stalled beat changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && plan_empty |-> joint_torque == 32'sd0)
    else $error("empty plan gave non-zero torque");

  a_last_joint: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> joint_index == 3'(NUM_JOINTS - 1))
    else $error("last flag on wrong joint");

endmodule

bind timed_ff_fb_cartesian_control_core tfcc_checker u_tfcc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .joint_torque (joint_torque),
  .joint_index  (joint_index),
  .plan_empty   (plan_empty),
  .last         (last)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for timed_ff_fb_cartesian_control_core.
// Holds its own torque predictor and checks every output beat; needs tfcc_pkg.
`timescale 1ns / 1ps

module testbench;
  import tfcc_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int MEAS_LATENCY = 400;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    req_t        rt;
    logic [12:0] addr;
    logic [63:0] value;
    logic [62:0] now;
    logic [5:0][31:0] vec;
    logic [2:0]  col;
  } beat_t;

  typedef struct packed {
    logic [31:0] torque;
    logic [2:0]  joint;
    logic [5:0]  sample;
    logic        empty;
    logic        fin;
  } torque_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [12:0] load_addr = '0;
  logic signed [63:0] load_value = '0;
  logic [62:0] meas_time = '0;
  logic signed [31:0] vec_0 = '0, vec_1 = '0, vec_2 = '0;
  logic signed [31:0] vec_3 = '0, vec_4 = '0, vec_5 = '0;
  logic [2:0] col_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] joint_torque;
  logic [2:0] joint_index;
  logic [5:0] chosen_sample;
  logic plan_empty;
  logic last;

  // Predictor state.
  logic [63:0] plan_mem [STORE_WORDS];
  bit plan_known [STORE_WORDS];
  int unsigned samples_set;
  logic signed [31:0] wrench [WRENCH_DIM];
  int unsigned picked;
  torque_t torque_q[$];

  int send_idle = 0;
  int recv_idle = 0;
  bit hold_on = 1'b0;
  int hold_cnt = 0;
  int errors = 0;
  int n_results = 0;
  int n_meas = 0;

  timed_ff_fb_cartesian_control_core u_dut (.*);

  always #HALF_PERIOD clk = ~clk;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint lo32(input logic [63:0] w);
    return longint'($signed(w[31:0]));
  endfunction

  // Finds the sample a measurement would choose; returns 0 if that would
  // touch a plan word that has never been written.
  function automatic bit choose_sample(input longint now, output int unsigned sel);
    int unsigned base;
    int unsigned i;
    base = samples_set > TAIL_SAMPLES ? samples_set - TAIL_SAMPLES : 0;
    sel = 0;
    if (samples_set == 0) return 1'b1;
    for (i = 0; i < base; i++) begin
      if (!plan_known[i * SAMPLE_WORDS]) return 1'b0;
      if ($signed(plan_mem[i * SAMPLE_WORDS]) > now) break;
    end
    if (i < base && i > 0) i--;
    sel = i;
    for (int k = 1; k <= 84; k++) begin
      if (!plan_known[i * SAMPLE_WORDS + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_beat(input beat_t b);
    int unsigned sel;
    longint err [ERR_DIM];
    longint acc;
    int unsigned w;
    torque_t t;
    case (b.rt)
      REQ_LOAD: begin
        plan_mem[b.addr] = b.value;
        plan_known[b.addr] = 1'b1;
      end
      REQ_COUNT: begin
        if (b.value[63]) samples_set = 0;
        else if (b.value > MAX_SAMPLES) samples_set = MAX_SAMPLES;
        else samples_set = 32'(b.value);
      end
      REQ_MEAS: begin
        n_meas++;
        void'(choose_sample(longint'({1'b0, b.now}), sel));
        picked = sel;
        if (samples_set == 0) begin
          foreach (wrench[r]) wrench[r] = '0;
        end else begin
          w = sel * SAMPLE_WORDS;
          foreach (err[r]) err[r] = 0;
          for (int r = 0; r < 3; r++) begin
            err[r] = clamp32(lo32(plan_mem[w + OFS_POS + r]) - lo32(64'(b.vec[r])));
            err[6 + r] = clamp32(lo32(plan_mem[w + 10 + r]) - lo32(64'(b.vec[3 + r])));
          end
          for (int r = 0; r < WRENCH_DIM; r++) begin
            acc = lo32(plan_mem[w + OFS_FF + r]);
            for (int c = 0; c < ERR_DIM; c++)
              acc += (lo32(plan_mem[w + OFS_GAIN + r * ERR_DIM + c]) * err[c]) >>> FRAC_BITS;
            wrench[r] = clamp32(acc);
          end
        end
      end
      default: begin
        acc = 0;
        for (int r = 0; r < WRENCH_DIM; r++)
          acc += (lo32(64'(b.vec[r])) * longint'(wrench[r])) >>> FRAC_BITS;
        t.torque = samples_set == 0 ? 32'd0 : clamp32(acc);
        t.joint = b.col;
        t.sample = picked[5:0];
        t.empty = samples_set == 0;
        t.fin = b.col == 3'(NUM_JOINTS - 1);
        torque_q.push_back(t);
      end
    endcase
  endtask

  // Offers one beat, holding it until the core takes it.
  task automatic send_beat(input beat_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= b.rt;
    load_addr <= b.addr;
    load_value <= b.value;
    meas_time <= b.now;
    vec_0 <= b.vec[0];
    vec_1 <= b.vec[1];
    vec_2 <= b.vec[2];
    vec_3 <= b.vec[3];
    vec_4 <= b.vec[4];
    vec_5 <= b.vec[5];
    col_index <= b.col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(b);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    go_quiet();
    while (torque_q.size() != 0) @(posedge clk);
    repeat (MEAS_LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  function automatic beat_t blank(input req_t rt);
    beat_t b;
    b = '0;
    b.rt = rt;
    b.addr = 13'($urandom);
    b.value = {$urandom, $urandom};
    b.now = 63'({$urandom, $urandom});
    b.col = 3'($urandom);
    for (int r = 0; r < 6; r++) b.vec[r] = $urandom;
    return b;
  endfunction

  task automatic put_word(input int unsigned a, input logic [63:0] v);
    beat_t b;
    b = blank(REQ_LOAD);
    b.addr = 13'(a);
    b.value = v;
    send_beat(b);
  endtask

  task automatic put_count(input logic [63:0] v);
    beat_t b;
    b = blank(REQ_COUNT);
    b.value = v;
    send_beat(b);
  endtask

  task automatic measure_at(input logic [62:0] t);
    beat_t b;
    b = blank(REQ_MEAS);
    b.now = t;
    for (int r = 0; r < 6; r++) b.vec[r] = rand_q();
    send_beat(b);
  endtask

  task automatic column(input logic [2:0] c);
    beat_t b;
    b = blank(REQ_COL);
    b.col = c;
    for (int r = 0; r < 6; r++) b.vec[r] = rand_q();
    send_beat(b);
  endtask

  task automatic test_empty_plan();
    measure_at('0);
    column(3'd0);
    column(3'd6);
  endtask

  // Samples 0-3, 62 and 63 in full, and the times of all samples.
  task automatic test_load_plan();
    int s;
    for (int k = 0; k < 6; k++) begin
      s = k < 4 ? k : 58 + k;
      put_word(s * SAMPLE_WORDS, 64'(s * 1000));
      for (int w = 1; w <= 84; w++) put_word(s * SAMPLE_WORDS + w, {$urandom, rand_q()});
    end
    for (int k = 4; k < 62; k++) put_word(k * SAMPLE_WORDS, 64'(k * 1000));
    put_word(13'h1FFF, '1);
  endtask

  task automatic test_directed();
    put_count(64'd1);
    measure_at('1);
    column(3'd6);
    put_count(64'd2);
    measure_at('0);
    column(3'd7);
    put_count(64'd4);
    measure_at(63'd1500);
    column(3'd1);
    measure_at(63'd0);
    column(3'd2);
    put_count(64'd100);
    measure_at(63'd2500);
    column(3'd5);
    put_count(64'h8000_0000_0000_0000);
    measure_at(63'd10);
    column(3'd4);
    put_count(64'd64);
    measure_at(63'd500);
    column(3'd6);
  endtask

  function automatic beat_t random_beat();
    beat_t b;
    int unsigned sel;
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      b = blank(REQ_LOAD);
      if ($urandom_range(3) != 0) b.addr = {2'($urandom), 4'd0, 7'($urandom)};
      if (b.addr[6:0] == 0 && $urandom_range(3) != 0) b.value = 64'($urandom_range(5000));
      else if ($urandom_range(1)) b.value = {$urandom, rand_q()};
    end else if (pick < 26) begin
      b = blank(REQ_COUNT);
      case ($urandom_range(5))
        0: b.value = 64'd0;
        1: b.value = 64'd64;
        2: b.value = 64'd65 + 64'($urandom_range(100));
        3: ;
        default: b.value = 64'($urandom_range(1, 4));
      endcase
    end else begin
      b = blank(pick < 45 ? REQ_MEAS : REQ_COL);
      if ($urandom_range(3) != 0) b.now = 63'($urandom_range(6000));
      if (pick >= 45 && $urandom_range(7) != 0) b.col = 3'($urandom_range(6));
      for (int r = 0; r < 6; r++) b.vec[r] = rand_q();
      // A measurement that would read unwritten plan words becomes a column.
      if (b.rt == REQ_MEAS && !choose_sample(longint'({1'b0, b.now}), sel)) begin
        b.rt = REQ_COL;
        b.col = 3'($urandom_range(6));
      end
    end
    return b;
  endfunction

  task automatic test_random(input int n, input int s_idle, input int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) send_beat(random_beat());
    wait_drained();
  endtask

  // The receiver holds off while column beats keep coming, so the core
  // backs up and stalls its input.
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_on <= 1'b1;
    repeat (30) column(3'($urandom_range(6)));
    hold_on <= 1'b0;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!hold_on) hold_cnt <= 0;
    else if (hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_on && hold_cnt < HOLD_CYCLES) out_stall <= 1'b1;
    else out_stall <= $urandom_range(99) < recv_idle;
  end

  always @(posedge clk) begin
    torque_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (torque_q.size() == 0) begin
        $error("torque beat with nothing expected");
        errors++;
      end else begin
        e = torque_q.pop_front();
        if (joint_torque !== e.torque) begin
          $error("joint_torque expected %0d got %0d", $signed(e.torque), joint_torque);
          errors++;
        end
        if (joint_index !== e.joint) begin
          $error("joint_index expected %0d got %0d", e.joint, joint_index);
          errors++;
        end
        if (chosen_sample !== e.sample) begin
          $error("chosen_sample expected %0d got %0d", e.sample, chosen_sample);
          errors++;
        end
        if (plan_empty !== e.empty) begin
          $error("plan_empty expected %0b got %0b", e.empty, plan_empty);
          errors++;
        end
        if (last !== e.fin) begin
          $error("last expected %0b got %0b", e.fin, last);
          errors++;
        end
      end
    end
  end

  initial begin
    samples_set = 0;
    picked = 0;
    foreach (wrench[r]) wrench[r] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_plan();
    test_load_plan();
    test_directed();
    wait_drained();
    test_backpressure();
    test_random(140, 14, 68);
    test_random(140, 68, 14);
    test_random(140, 0, 0);
    $display("Covered %0d measurements and %0d torque beats over empty, short and full plans,",
             n_meas, n_results);
    $display("with back-pressure, sender pauses and both idling patterns.");
    if (errors == 0 && torque_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
